// File: sv/pbsc_pkg.sv
// ----------------------------------------------------------------------------
// pbsc_pkg
// Shared types, codes, constants and CRC helpers for the pulse-width bit-cell
// encoder.
// ----------------------------------------------------------------------------
package pbsc_pkg;

  localparam int unsigned MaxResults = 20;
  localparam int unsigned ResCntW    = 5;

  localparam logic [15:0] CrcPoly  = 16'h8408;
  localparam logic [7:0]  SyncByte = 8'h7E;

  localparam logic [7:0]  MarkTimeRst    = 8'd18;
  localparam logic [7:0]  SpaceTimeRst   = 8'd14;
  localparam logic [7:0]  OneExtraRst    = 8'd16;
  localparam logic [15:0] FlushMarkerRst = 16'd18010;
  localparam logic [2:0]  StuffRunRst    = 3'd5;

  typedef enum logic [2:0] {
    CMD_DATA  = 3'd0,
    CMD_SYNC  = 3'd1,
    CMD_FLUSH = 3'd2,
    CMD_START = 3'd3,
    CMD_CRC   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MARK_TIME   = 3'd0,
    REG_SPACE_TIME  = 3'd1,
    REG_ONE_EXTRA   = 3'd2,
    REG_FLUSH_MARK  = 3'd3,
    REG_STUFF_RUN   = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_STUFF,
    ST_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_BIT,
    OP_STUFF,
    OP_FLUSH
  } op_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_e  op;
    logic next_byte;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic adv;
    logic stuff_need;
    logic last_bit;
    logic byte_end;
    logic pending;
  } stat_t;

  // One entry of the reflected table, computed by eight shift steps.
  function automatic logic [15:0] crc_table_entry(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    return {crc[7:0], 8'h00} ^ crc_table_entry(crc[15:8] ^ b);
  endfunction

endpackage

// File: sv/pbsc_if.sv
// ----------------------------------------------------------------------------
// pbsc_if
// Valid/ready channels for command words in and bit-cell words out.
// ----------------------------------------------------------------------------
interface pbsc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface pbsc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] rise_time;
  logic [15:0] fall_time;
  logic        bit_value;
  logic        stuffed;
  logic        last;

  modport source (output valid, kind, rise_time, fall_time, bit_value, stuffed, last,
                  input ready);
  modport sink   (input valid, kind, rise_time, fall_time, bit_value, stuffed, last,
                  output ready);
endinterface

// File: sv/pcm_bit_stuff_crc_pulse_encoder_core.sv
// A command word is taken while the encoder is idle; after that the encoder
// produces one bit cell per cycle while the output is not stalled, from a single
// timestamp adder chain, so a data byte makes 8 to 16 cells (each stuffing zero
// adds a cell), a CRC command 16 to 32, a sync head 8, a flush one marker word,
// and start or an unknown code none. Cells beyond the twentieth of a command are
// not output but still advance the CRC, run counter and timestamp. Configuration
// is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it
// only while no command is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
// pcm_bit_stuff_crc_pulse_encoder_core
// Pulse-width bit-cell encoder with CRC-16 and zero-bit stuffing.
// ----------------------------------------------------------------------------
module pcm_bit_stuff_crc_pulse_encoder_core import pbsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  pbsc_in_if.sink     in_i,
  pbsc_out_if.source  out_o
);

  ctrl_t ctrl;
  stat_t stat;

  pbsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .stat_i     (stat),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  pbsc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .ctrl_i          (ctrl),
    .in_cmd_i        (in_i.cmd),
    .in_data_byte_i  (in_i.data_byte),
    .out_ready_i     (out_o.ready),
    .stat_o          (stat),
    .out_valid_o     (out_o.valid),
    .out_kind_o      (out_o.kind),
    .out_rise_time_o (out_o.rise_time),
    .out_fall_time_o (out_o.fall_time),
    .out_bit_value_o (out_o.bit_value),
    .out_stuffed_o   (out_o.stuffed),
    .out_last_o      (out_o.last)
  );

`ifndef SYNTHESIS
  // A flush marker word is always the only and therefore last word of its command.
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind) |-> (out_o.last && out_o.fall_time == 16'h0000))
    else $error("flush marker word not marked last");

  // A stuffing cell is always a zero bit cell.
  a_stuff_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stuffed) |-> (!out_o.bit_value && !out_o.kind))
    else $error("stuffing cell is not a zero bit cell");

  // Commands that make bit cells keep the encoder busy for at least the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready &&
     (in_i.cmd == CMD_DATA || in_i.cmd == CMD_SYNC || in_i.cmd == CMD_CRC))
    |=> !in_i.ready)
    else $error("encoder took a command while cells were pending");
`endif

endmodule

// File: sv/pbsc_ctrl.sv
// ----------------------------------------------------------------------------
// pbsc_ctrl
// Sequencer: takes a command word, then steps the datapath one bit cell per
// cycle unless stalled, inserting stuffing cells; chains the second CRC byte.
// ----------------------------------------------------------------------------
module pbsc_ctrl import pbsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_cmd_i,
  input  stat_t      stat_i,
  output logic       in_ready_o,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    ctrl_o.op         = OP_NONE;
    ctrl_o.next_byte  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = OP_LOAD;
          if (in_cmd_i == CMD_DATA || in_cmd_i == CMD_SYNC || in_cmd_i == CMD_CRC) begin
            state_d = ST_CELL;
          end else if (in_cmd_i == CMD_FLUSH) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_CELL: begin
        if (stat_i.adv) begin
          ctrl_o.op = OP_BIT;
          if (stat_i.stuff_need) begin
            state_d = ST_STUFF;
          end else if (stat_i.last_bit) begin
            if (stat_i.pending) begin
              ctrl_o.next_byte = 1'b1;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_STUFF: begin
        if (stat_i.adv) begin
          ctrl_o.op = OP_STUFF;
          if (stat_i.byte_end && !stat_i.pending) begin
            state_d = ST_IDLE;
          end else begin
            ctrl_o.next_byte = stat_i.byte_end;
            state_d          = ST_CELL;
          end
        end
      end
      ST_FLUSH: begin
        if (stat_i.adv) begin
          ctrl_o.op = OP_FLUSH;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/pbsc_datapath.sv
// ----------------------------------------------------------------------------
// pbsc_datapath
// Configuration registers, CRC, run-of-ones counter, timestamp accumulator,
// bit shifter and the output word register.
// ----------------------------------------------------------------------------
module pbsc_datapath import pbsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  ctrl_t       ctrl_i,
  input  logic [2:0]  in_cmd_i,
  input  logic [7:0]  in_data_byte_i,
  input  logic        out_ready_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  output logic        out_kind_o,
  output logic [15:0] out_rise_time_o,
  output logic [15:0] out_fall_time_o,
  output logic        out_bit_value_o,
  output logic        out_stuffed_o,
  output logic        out_last_o
);

  logic [7:0]  mark_q, space_q, extra_q;
  logic [15:0] flush_q;
  logic [2:0]  stuff_run_q;

  logic [15:0] crc_q, crc_d;
  logic [2:0]  ones_q, ones_d;
  logic [15:0] ts_q, ts_d;
  logic [7:0]  sh_q, sh_d;
  logic [7:0]  lo_q, lo_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        byte_end_q, byte_end_d;
  logic        pending_q, pending_d;
  logic        raw_q, raw_d;
  logic [ResCntW-1:0] res_cnt_q, res_cnt_d;

  logic        valid_q, valid_d;
  logic        kind_q, kind_d;
  logic [15:0] rise_q, rise_d;
  logic [15:0] fall_q, fall_d;
  logic        bit_q, bit_d;
  logic        stf_q, stf_d;
  logic        last_q, last_d;

  logic        emit_ok, slot_free, limit_hit;
  logic        bitv, stuff_need, cell_bit;
  logic [2:0]  ones_next;
  logic [3:0]  thr;
  logic [7:0]  crc_byte;
  logic [15:0] crc_next;
  logic [15:0] cell_rise, cell_fall, low_time;

  // Configuration writes; indexes outside the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q      <= MarkTimeRst;
      space_q     <= SpaceTimeRst;
      extra_q     <= OneExtraRst;
      flush_q     <= FlushMarkerRst;
      stuff_run_q <= StuffRunRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MARK_TIME:  mark_q      <= cfg_data_i[7:0];
        REG_SPACE_TIME: space_q     <= cfg_data_i[7:0];
        REG_ONE_EXTRA:  extra_q     <= cfg_data_i[7:0];
        REG_FLUSH_MARK: flush_q     <= cfg_data_i;
        REG_STUFF_RUN:  stuff_run_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign emit_ok   = res_cnt_q < ResCntW'(MaxResults);
  assign limit_hit = res_cnt_q == ResCntW'(MaxResults - 1);
  assign slot_free = !valid_q || out_ready_i;

  // A stuff run of zero disables stuffing: the threshold of eight is never met.
  assign thr        = (stuff_run_q == 3'd0) ? 4'd8 : {1'b0, stuff_run_q};
  assign bitv       = sh_q[7];
  assign ones_next  = bitv ? ((ones_q == 3'd7) ? 3'd7 : ones_q + 3'd1) : 3'd0;
  assign stuff_need = !raw_q && ({1'b0, ones_next} >= thr);

  assign stat_o.adv        = slot_free || !emit_ok;
  assign stat_o.stuff_need = stuff_need;
  assign stat_o.last_bit   = cnt_q == 3'd0;
  assign stat_o.byte_end   = byte_end_q;
  assign stat_o.pending    = pending_q;

  // One shared table lookup serves both the first and the chained byte.
  always_comb begin
    if (ctrl_i.next_byte) begin
      crc_byte = lo_q;
    end else if (in_cmd_i == CMD_CRC) begin
      crc_byte = crc_q[15:8];
    end else begin
      crc_byte = in_data_byte_i;
    end
  end
  assign crc_next = crc_update(crc_q, crc_byte);

  assign cell_bit  = (ctrl_i.op == OP_BIT) ? bitv : 1'b0;
  assign low_time  = {8'h00, space_q} + (cell_bit ? {8'h00, extra_q} : 16'h0000);
  assign cell_rise = ts_q + {8'h00, mark_q};
  assign cell_fall = cell_rise + low_time;

  always_comb begin
    crc_d      = crc_q;
    ones_d     = ones_q;
    ts_d       = ts_q;
    sh_d       = sh_q;
    lo_d       = lo_q;
    cnt_d      = cnt_q;
    byte_end_d = byte_end_q;
    pending_d  = pending_q;
    raw_d      = raw_q;
    res_cnt_d  = res_cnt_q;
    valid_d    = out_ready_i ? 1'b0 : valid_q;
    kind_d     = kind_q;
    rise_d     = rise_q;
    fall_d     = fall_q;
    bit_d      = bit_q;
    stf_d      = stf_q;
    last_d     = last_q;

    case (ctrl_i.op)
      OP_LOAD: begin
        res_cnt_d  = '0;
        cnt_d      = 3'd7;
        byte_end_d = 1'b0;
        pending_d  = 1'b0;
        raw_d      = 1'b0;
        case (in_cmd_i)
          CMD_DATA: begin
            crc_d = crc_next;
            sh_d  = in_data_byte_i;
          end
          CMD_SYNC: begin
            sh_d  = SyncByte;
            raw_d = 1'b1;
          end
          CMD_CRC: begin
            crc_d     = crc_next;
            sh_d      = crc_q[15:8];
            lo_d      = crc_q[7:0];
            pending_d = 1'b1;
          end
          CMD_START: begin
            crc_d  = '0;
            ones_d = '0;
            ts_d   = '0;
          end
          default: ;
        endcase
      end
      OP_BIT: begin
        ts_d       = cell_fall;
        sh_d       = {sh_q[6:0], 1'b0};
        cnt_d      = cnt_q - 3'd1;
        byte_end_d = cnt_q == 3'd0;
        if (!raw_q) begin
          ones_d = stuff_need ? 3'd0 : ones_next;
        end
        if (emit_ok) begin
          res_cnt_d = res_cnt_q + ResCntW'(1);
          valid_d   = 1'b1;
          kind_d    = 1'b0;
          rise_d    = cell_rise;
          fall_d    = cell_fall;
          bit_d     = bitv;
          stf_d     = 1'b0;
          last_d    = ((cnt_q == 3'd0) && !pending_q && !stuff_need) || limit_hit;
        end
      end
      OP_STUFF: begin
        ts_d = cell_fall;
        if (emit_ok) begin
          res_cnt_d = res_cnt_q + ResCntW'(1);
          valid_d   = 1'b1;
          kind_d    = 1'b0;
          rise_d    = cell_rise;
          fall_d    = cell_fall;
          bit_d     = 1'b0;
          stf_d     = 1'b1;
          last_d    = (byte_end_q && !pending_q) || limit_hit;
        end
      end
      OP_FLUSH: begin
        res_cnt_d = res_cnt_q + ResCntW'(1);
        valid_d   = 1'b1;
        kind_d    = 1'b1;
        rise_d    = flush_q;
        fall_d    = '0;
        bit_d     = 1'b0;
        stf_d     = 1'b0;
        last_d    = 1'b1;
      end
      default: ;
    endcase

    // The second CRC byte takes over the shifter once the first one is done.
    if (ctrl_i.next_byte) begin
      crc_d      = crc_next;
      sh_d       = lo_q;
      cnt_d      = 3'd7;
      byte_end_d = 1'b0;
      pending_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= '0;
      ones_q     <= '0;
      ts_q       <= '0;
      cnt_q      <= '0;
      byte_end_q <= 1'b0;
      pending_q  <= 1'b0;
      raw_q      <= 1'b0;
      res_cnt_q  <= '0;
      valid_q    <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      ones_q     <= ones_d;
      ts_q       <= ts_d;
      cnt_q      <= cnt_d;
      byte_end_q <= byte_end_d;
      pending_q  <= pending_d;
      raw_q      <= raw_d;
      res_cnt_q  <= res_cnt_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    lo_q   <= lo_d;
    kind_q <= kind_d;
    rise_q <= rise_d;
    fall_q <= fall_d;
    bit_q  <= bit_d;
    stf_q  <= stf_d;
    last_q <= last_d;
  end

  assign out_valid_o     = valid_q;
  assign out_kind_o      = kind_q;
  assign out_rise_time_o = rise_q;
  assign out_fall_time_o = fall_q;
  assign out_bit_value_o = bit_q;
  assign out_stuffed_o   = stf_q;
  assign out_last_o      = last_q;

endmodule

// File: bench/tb_pcm_bit_stuff_crc_pulse_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcm_bit_stuff_crc_pulse_encoder_core
// Self-checking bench for the bit-cell encoder. A short scripted sequence
// covers the field extremes, every command, the spare codes, timestamp wrap,
// disabled stuffing and cut-off commands. Random frames and noise follow under
// several register settings. Every output word is checked against a cell
// predictor run at command acceptance.
// ----------------------------------------------------------------------------
module tb_pcm_bit_stuff_crc_pulse_encoder_core;
  import pbsc_pkg::*;

  localparam int HoldCycles = 400;
  localparam int Settle     = 48;
  localparam int CycleLimit = 1000000;
  localparam int RandWords  = 290;
  localparam int Phases     = 5;

  localparam logic [2:0] CmdSpareLo  = 3'd5;
  localparam logic [2:0] CmdSpareMid = 3'd6;
  localparam logic [2:0] CmdSpareHi  = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [15:0] rise;
    logic [15:0] fall;
    logic        bitv;
    logic        stuffed;
    logic        last;
  } cell_t;

  // One scripted step: a register write or a command word. A typed count of
  // -1 means the cells come from the predictor.
  typedef struct {
    bit          is_cfg;
    reg_e        idx;
    logic [15:0] val;
    logic [2:0]  cmd;
    logic [7:0]  data;
    int          typed_n;
  } step_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [2:0]  cfg_idx_i  = 3'd0;
  logic [15:0] cfg_data_i = 16'd0;

  pbsc_in_if  cmd_if ();
  pbsc_out_if cell_if ();

  pcm_bit_stuff_crc_pulse_encoder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_if),
    .out_o      (cell_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor registers and state.
  logic [7:0]  tick_mark  = MarkTimeRst;
  logic [7:0]  tick_space = SpaceTimeRst;
  logic [7:0]  tick_extra = OneExtraRst;
  logic [15:0] marker_val = FlushMarkerRst;
  logic [2:0]  run_limit  = StuffRunRst;
  logic [15:0] crc_acc    = 16'd0;
  int          ones_seen  = 0;
  logic [15:0] stamp      = 16'd0;

  cell_t burst[$];
  cell_t cells_due[$];
  step_t script[$];

  int  cell_total;
  int  mismatches    = 0;
  int  cells_checked = 0;
  int  words_sent    = 0;
  int  frames        = 0;
  int  cut_commands  = 0;
  int  settings_used = 0;
  int  holds_done    = 0;
  int  cycles        = 0;
  bit  calm          = 1'b0;
  bit  hold_req      = 1'b0;

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    t = {8'h00, crc[15:8] ^ b};
    for (int k = 0; k < 8; k++) begin
      t = t[0] ? ((t >> 1) ^ CrcPoly) : (t >> 1);
    end
    return {crc[7:0], 8'h00} ^ t;
  endfunction

  // Only the first MaxResults cells of a command reach the output.
  task automatic keep(input cell_t c);
    cell_total++;
    if (burst.size() < MaxResults) burst.push_back(c);
  endtask

  task automatic put_cell(input logic bitv, input logic stf);
    cell_t c;
    stamp = stamp + {8'h00, tick_mark};
    c.kind = 1'b0;
    c.rise = stamp;
    stamp = stamp + {8'h00, tick_space};
    if (bitv) stamp = stamp + {8'h00, tick_extra};
    c.fall    = stamp;
    c.bitv    = bitv;
    c.stuffed = stf;
    c.last    = 1'b0;
    keep(c);
  endtask

  task automatic send_bit(input logic b);
    int thr;
    thr = (run_limit == 3'd0) ? 8 : int'(run_limit);
    if (b) begin
      if (ones_seen < 7) ones_seen++;
      put_cell(1'b1, 1'b0);
    end else begin
      ones_seen = 0;
      put_cell(1'b0, 1'b0);
    end
    if (ones_seen >= thr) begin
      ones_seen = 0;
      put_cell(1'b0, 1'b1);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    crc_acc = crc_next(crc_acc, b);
    for (int i = 7; i >= 0; i--) send_bit(b[i]);
  endtask

  task automatic encode_command(input logic [2:0] c, input logic [7:0] d);
    logic [15:0] snap;
    cell_t       m;
    burst.delete();
    cell_total = 0;
    case (c)
      CMD_DATA: send_byte(d);
      CMD_SYNC: begin
        for (int i = 7; i >= 0; i--) put_cell(SyncByte[i], 1'b0);
      end
      CMD_FLUSH: begin
        m = '0;
        m.kind = 1'b1;
        m.rise = marker_val;
        keep(m);
      end
      CMD_START: begin
        crc_acc   = 16'd0;
        ones_seen = 0;
        stamp     = 16'd0;
      end
      CMD_CRC: begin
        snap = crc_acc;
        send_byte(snap[15:8]);
        send_byte(snap[7:0]);
      end
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    if (cell_total > MaxResults) cut_commands++;
    foreach (burst[i]) cells_due.push_back(burst[i]);
  endtask

  // Offers one command word and waits for the handshake. The predictor runs
  // at the accepting edge.
  task automatic offer_word(input logic [2:0] c, input logic [7:0] d);
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_if.valid     <= 1'b1;
    cmd_if.cmd       <= c;
    cmd_if.data_byte <= d;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    encode_command(c, d);
    if (c <= CMD_CRC) words_sent++;
  endtask

  // Registers change only once the encoder has drained and gone quiet.
  task automatic write_reg(input reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MARK_TIME:  tick_mark  = val[7:0];
      REG_SPACE_TIME: tick_space = val[7:0];
      REG_ONE_EXTRA:  tick_extra = val[7:0];
      REG_FLUSH_MARK: marker_val = val;
      REG_STUFF_RUN:  run_limit  = val[2:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] m, input logic [7:0] s, input logic [7:0] e,
                              input logic [15:0] f, input logic [2:0] r);
    write_reg(REG_MARK_TIME, {8'h00, m});
    write_reg(REG_SPACE_TIME, {8'h00, s});
    write_reg(REG_ONE_EXTRA, {8'h00, e});
    write_reg(REG_FLUSH_MARK, f);
    write_reg(REG_STUFF_RUN, {13'd0, r});
    settings_used++;
  endtask

  task automatic add_row(input bit is_cfg, input reg_e idx, input logic [15:0] val,
                         input logic [2:0] c, input logic [7:0] d, input int typed_n);
    step_t s;
    s.is_cfg  = is_cfg;
    s.idx     = idx;
    s.val     = val;
    s.cmd     = c;
    s.data    = d;
    s.typed_n = typed_n;
    script.push_back(s);
  endtask

  task automatic build_script();
    // Reset settings: marker, spare codes, plain bytes, sync and CRC.
    add_row(0, REG_MARK_TIME, FlushMarkerRst, CMD_FLUSH, 8'h00, 1);
    add_row(0, REG_MARK_TIME, 16'd0, CmdSpareLo, 8'hFF, 0);
    add_row(0, REG_MARK_TIME, 16'd0, CmdSpareHi, 8'h00, 0);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'h00, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hFF, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_SYNC, 8'h00, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hA5, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_CRC, 8'h00, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_START, 8'h5A, 0);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'h7E, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CmdSpareMid, 8'h3C, 0);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_CRC, 8'h00, -1);
    // Largest times make the timestamp advance fastest toward its wrap.
    add_row(1, REG_MARK_TIME, 16'd255, CMD_DATA, 8'h00, -1);
    add_row(1, REG_SPACE_TIME, 16'd255, CMD_DATA, 8'h00, -1);
    add_row(1, REG_ONE_EXTRA, 16'd255, CMD_DATA, 8'h00, -1);
    add_row(1, REG_FLUSH_MARK, 16'hFFFF, CMD_DATA, 8'h00, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hFF, -1);
    add_row(0, REG_MARK_TIME, 16'hFFFF, CMD_FLUSH, 8'hFF, 1);
    // A stuffing zero after every one: CRC commands run past the cell cap.
    add_row(1, REG_STUFF_RUN, 16'd1, CMD_DATA, 8'h00, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hFF, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hEF, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_CRC, 8'h00, -1);
    // Stuffing off and zero times: the run of ones saturates.
    add_row(1, REG_STUFF_RUN, 16'd0, CMD_DATA, 8'h00, -1);
    add_row(1, REG_MARK_TIME, 16'd0, CMD_DATA, 8'h00, -1);
    add_row(1, REG_SPACE_TIME, 16'd0, CMD_DATA, 8'h00, -1);
    add_row(1, REG_ONE_EXTRA, 16'd0, CMD_DATA, 8'h00, -1);
    add_row(1, REG_FLUSH_MARK, 16'd0, CMD_DATA, 8'h00, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hFF, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hFF, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_SYNC, 8'hFF, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_FLUSH, 8'h00, 1);
    add_row(1, REG_STUFF_RUN, 16'd7, CMD_DATA, 8'h00, -1);
    add_row(1, REG_MARK_TIME, 16'd3, CMD_DATA, 8'h00, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hFF, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_DATA, 8'hFE, -1);
    add_row(0, REG_MARK_TIME, 16'd0, CMD_CRC, 8'h00, -1);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = 8'hFF;
      1: b = 8'h00;
      2: b = 8'hFF ^ (8'h01 << $urandom_range(0, 7));
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  task automatic run_frame();
    int n;
    n = $urandom_range(1, 5);
    if ($urandom_range(0, 2) == 0) offer_word(CMD_START, 8'($urandom));
    offer_word(CMD_SYNC, 8'($urandom));
    repeat (n) offer_word(CMD_DATA, pick_byte());
    if ($urandom_range(0, 5) != 0) offer_word(CMD_CRC, 8'($urandom));
    offer_word(CMD_SYNC, 8'($urandom));
    if ($urandom_range(0, 2) == 0) offer_word(CMD_FLUSH, 8'($urandom));
    frames++;
  endtask

  // Output side: random stalls, one long hold while the input keeps coming.
  initial begin : receiver
    int n;
    cell_if.ready = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        cell_if.ready <= 1'b0;
        for (n = 1; n < HoldCycles; n++) @(negedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        @(negedge clk_i);
        cell_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        cell_if.ready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cell_t got;
    cell_t want;
    if (rst_ni && cell_if.valid && cell_if.ready) begin
      got = {cell_if.kind, cell_if.rise_time, cell_if.fall_time,
             cell_if.bit_value, cell_if.stuffed, cell_if.last};
      if (cells_due.size() == 0) begin
        if (mismatches < 10)
          $display("cycle %0d: unexpected word kind=%0d rise=%0d fall=%0d bit=%0d stf=%0d last=%0d",
                   cycles, got.kind, got.rise, got.fall, got.bitv, got.stuffed, got.last);
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        cells_checked++;
        if (got.kind !== want.kind || got.rise !== want.rise || got.fall !== want.fall ||
            got.bitv !== want.bitv || got.stuffed !== want.stuffed || got.last !== want.last) begin
          if (mismatches < 10) begin
            $display("cycle %0d: expected kind=%0d rise=%0d fall=%0d bit=%0d stf=%0d last=%0d",
                     cycles, want.kind, want.rise, want.fall, want.bitv, want.stuffed, want.last);
            $display("           actual   kind=%0d rise=%0d fall=%0d bit=%0d stf=%0d last=%0d",
                     got.kind, got.rise, got.fall, got.bitv, got.stuffed, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, cells_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    step_t row;
    int    target;
    int    calm_from;
    cmd_if.valid     = 1'b0;
    cmd_if.cmd       = CMD_DATA;
    cmd_if.data_byte = 8'h00;
    build_script();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    settings_used = 1;

    foreach (script[i]) begin
      row = script[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.val);
      end else begin
        offer_word(row.cmd, row.data);
        if (row.typed_n >= 0) begin
          // Rows whose outcome is plain replace the predicted cells.
          repeat (burst.size()) void'(cells_due.pop_back());
          if (row.typed_n == 1)
            cells_due.push_back({1'b1, row.val, 16'd0, 1'b0, 1'b0, 1'b1});
        end
      end
    end

    calm_from = words_sent + RandWords - RandWords / 7;
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: program_regs(MarkTimeRst, SpaceTimeRst, OneExtraRst, FlushMarkerRst, StuffRunRst);
        1: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                        3'($urandom_range(1, 7)));
        2: program_regs(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 3'd1);
        3: program_regs(8'h00, 8'h00, 8'h00, 16'h0000, 3'd0);
        default: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                              3'($urandom_range(0, 7)));
      endcase
      if (ph == 2) hold_req = 1'b1;
      target = words_sent + RandWords / Phases;
      while (words_sent < target) begin
        calm = (words_sent >= calm_from);
        if ($urandom_range(0, 4) != 0) begin
          run_frame();
        end else begin
          repeat ($urandom_range(1, 4)) offer_word(3'($urandom_range(0, 7)), 8'($urandom));
        end
      end
    end

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    mismatches += cells_due.size();

    $display("%0d commands in %0d random frames and noise, %0d register settings, %0d long hold",
             words_sent, frames, settings_used, holds_done);
    $display("%0d words checked, %0d commands cut at the cell cap, %0d mismatches",
             cells_checked, cut_commands, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
